// ===== design/tws_pkg.sv =====
// Package: shared widths, command and error codes, and reset values for the panel command engine.
`timescale 1ns / 1ps
`default_nettype none
package tws_pkg;

   localparam int CMD_W   = 3;
   localparam int BYTE_W  = 8;
   localparam int TPM_W   = 16;
   localparam int ERR_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int PROD_W  = BYTE_W + TPM_W;

   typedef logic [CMD_W-1:0]      command_type;
   typedef logic [BYTE_W-1:0]     byte_type;
   typedef logic [ERR_W-1:0]      error_type;
   typedef logic [CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // commands
   localparam command_type CMD_TICK     = 3'd0;
   localparam command_type CMD_WRITE_DC0 = 3'd1;
   localparam command_type CMD_WRITE_DC1 = 3'd2;
   localparam command_type CMD_WAIT_MS  = 3'd3;
   localparam command_type CMD_POWER    = 3'd4;
   localparam command_type CMD_READ     = 3'd5;

   // error codes
   localparam error_type ERR_NONE        = 2'd0;
   localparam error_type ERR_BUSY        = 2'd1;
   localparam error_type ERR_UNSUPPORTED = 2'd2;

   // register indexes
   localparam csr_index_type CSR_TICKS_PER_MS   = 2'd0;
   localparam csr_index_type CSR_PANEL_ID       = 2'd1;
   localparam csr_index_type CSR_BOARD_REVISION = 2'd2;

   localparam logic [TPM_W-1:0] TICKS_PER_MS_RESET = 16'd1000;

   // voltage select thresholds
   localparam byte_type PANEL_ID_LOW_LIMIT = 8'd2;
   localparam byte_type BOARD_REV_LOW_MAX  = 8'd2;

endpackage
`default_nettype wire

// ===== design/tws_channels.sv =====
// Interfaces: command transaction channel and result transaction channel.
`timescale 1ns / 1ps
`default_nettype none
interface tws_req_if
   import tws_pkg::*;
();
   logic        valid;
   logic        ready;
   command_type command;
   byte_type    value;
   logic        sdi_in;

   modport source (output valid, output command, output value, output sdi_in, input ready);
   modport sink   (input valid, input command, input value, input sdi_in, output ready);
endinterface

interface tws_rsp_if
   import tws_pkg::*;
();
   logic      valid;
   logic      ready;
   logic      spi_cs;
   logic      spi_clk;
   logic      spi_dout;
   logic      dout_enable;
   logic      busy_res;
   logic      power_request;
   logic      io_voltage_high;
   byte_type  read_data;
   logic      read_valid;
   error_type error;

   modport source (output valid, output spi_cs, output spi_clk, output spi_dout,
                   output dout_enable, output busy_res, output power_request,
                   output io_voltage_high, output read_data, output read_valid,
                   output error, input ready);
   modport sink   (input valid, input spi_cs, input spi_clk, input spi_dout,
                   input dout_enable, input busy_res, input power_request,
                   input io_voltage_high, input read_data, input read_valid,
                   input error, output ready);
endinterface
`default_nettype wire

// ===== design/three_wire_spi_panel_command_engine.sv =====
// Top level: tick-driven 3-wire 9-bit serial panel command engine.
// Result: registered, so a result transaction appears in the cycle after its tick transaction is accepted.
// Throughput: one tick transaction per cycle while results are taken; the result register
//   frees as it is taken, so input and output may both move every cycle.
// Reset (synchronous, active high): idle, chip select high, clock low, line
//   driven low, ticks_per_ms 1000, panel_id and board_revision 0, no result held.
`timescale 1ns / 1ps
`default_nettype none
module three_wire_spi_panel_command_engine
   import tws_pkg::*;
#(
   parameter int DELAY_COUNT_BITS = 24
) (
   input  wire                clock,
   input  wire                reset,
   tws_req_if.sink            req_ch,
   tws_rsp_if.source          rsp_ch,
   input  wire                csr_write_enable,
   input  wire csr_index_type csr_index,
   input  wire csr_data_type  csr_write_data
);

   // ---------------------------------------------------------------------
   // Sequencer phases
   // ---------------------------------------------------------------------
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_SEND    = 3'd1; // lead bit + 8 data bits out
   localparam logic [2:0] PH_WEND    = 3'd2; // raise chip select after a write
   localparam logic [2:0] PH_DELAY   = 3'd3; // millisecond wait
   localparam logic [2:0] PH_RELEASE = 3'd4; // let go of the data line
   localparam logic [2:0] PH_RECV    = 3'd5; // sample 8 bits
   localparam logic [2:0] PH_REND    = 3'd6; // close the read, hand out byte

   localparam int EXT_W = PROD_W + DELAY_COUNT_BITS;
   localparam logic [EXT_W-1:0] DELAY_MAX_EXT =
      {{PROD_W{1'b0}}, {DELAY_COUNT_BITS{1'b1}}};
   localparam logic [DELAY_COUNT_BITS-1:0] DELAY_ONE = DELAY_COUNT_BITS'(1);

   localparam logic [3:0] BITS_LAST = 4'd8;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [TPM_W-1:0] ticks_per_ms_ff;
   byte_type         panel_id_ff;
   byte_type         board_revision_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_ms_ff   <= TICKS_PER_MS_RESET;
         panel_id_ff       <= '0;
         board_revision_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TICKS_PER_MS:   ticks_per_ms_ff   <= csr_write_data;
            CSR_PANEL_ID:       panel_id_ff       <= csr_write_data[BYTE_W-1:0];
            CSR_BOARD_REVISION: board_revision_ff <= csr_write_data[BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: the result register parts the two sides
   // ---------------------------------------------------------------------
   logic rsp_valid_ff, rsp_valid_in;
   logic req_accept;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;

   // ---------------------------------------------------------------------
   // Sequencer state
   // ---------------------------------------------------------------------
   logic [2:0]                  phase_ff, phase_in;
   logic [3:0]                  bit_index_ff, bit_index_in;
   logic [1:0]                  sub_tick_ff, sub_tick_in;
   byte_type                    tx_shift_ff, tx_shift_in;
   byte_type                    rx_shift_ff, rx_shift_in;
   logic                        lead_bit_ff, lead_bit_in;
   logic                        is_read_ff, is_read_in;
   logic [DELAY_COUNT_BITS-1:0] delay_left_ff, delay_left_in;
   logic                        cs_ff, cs_in;
   logic                        clk_ff, clk_in;
   logic                        dout_ff, dout_in;
   logic                        oe_ff, oe_in;

   // delay length: value * ticks_per_ms, clipped to the counter width
   logic [PROD_W-1:0]           delay_prod;
   logic [EXT_W-1:0]            delay_prod_ext;
   logic [DELAY_COUNT_BITS-1:0] delay_total;
   logic [DELAY_COUNT_BITS-1:0] delay_dec;

   assign delay_prod     = PROD_W'(req_ch.value) * PROD_W'(ticks_per_ms_ff);
   assign delay_prod_ext = EXT_W'(delay_prod);
   assign delay_total    = (delay_prod_ext > DELAY_MAX_EXT) ? {DELAY_COUNT_BITS{1'b1}}
                                                            : delay_prod_ext[DELAY_COUNT_BITS-1:0];
   assign delay_dec      = (delay_left_ff != '0) ? delay_left_ff - DELAY_ONE : delay_left_ff;

   // bit on the line during a send: lead bit first, then the byte MSB first
   logic       send_bit;
   logic [3:0] shift_sel;
   logic [3:0] bit_next;

   assign shift_sel = BITS_LAST - bit_index_ff;
   assign send_bit  = (bit_index_ff == '0) ? lead_bit_ff : tx_shift_ff[shift_sel[2:0]];
   assign bit_next  = bit_index_ff + 4'd1;

   // per-transaction result flags
   error_type err_res;
   logic      power_res;
   logic      valid_res;

   always_comb begin
      phase_in      = phase_ff;
      bit_index_in  = bit_index_ff;
      sub_tick_in   = sub_tick_ff;
      tx_shift_in   = tx_shift_ff;
      rx_shift_in   = rx_shift_ff;
      lead_bit_in   = lead_bit_ff;
      is_read_in    = is_read_ff;
      delay_left_in = delay_left_ff;
      cs_in         = cs_ff;
      clk_in        = clk_ff;
      dout_in       = dout_ff;
      oe_in         = oe_ff;
      err_res       = ERR_NONE;
      power_res     = 1'b0;
      valid_res     = 1'b0;

      if (req_accept) begin
         if (phase_ff != PH_IDLE) begin
            // busy: any command is dropped, the tick still advances the job
            if (req_ch.command != CMD_TICK) begin
               err_res = ERR_BUSY;
            end
            case (phase_ff)
               PH_SEND: begin
                  case (sub_tick_ff)
                     2'd0: begin
                        cs_in       = 1'b0;
                        clk_in      = 1'b0;
                        dout_in     = send_bit;
                        oe_in       = 1'b1;
                        sub_tick_in = 2'd1;
                     end
                     2'd1: begin
                        clk_in      = 1'b1;
                        sub_tick_in = 2'd2;
                     end
                     default: begin
                        clk_in      = 1'b0;
                        sub_tick_in = 2'd0;
                        if (bit_index_ff >= BITS_LAST) begin
                           bit_index_in = '0;
                           phase_in     = is_read_ff ? PH_RELEASE : PH_WEND;
                        end else begin
                           bit_index_in = bit_next;
                        end
                     end
                  endcase
               end
               PH_WEND: begin
                  cs_in    = 1'b1;
                  phase_in = PH_IDLE;
               end
               PH_DELAY: begin
                  delay_left_in = delay_dec;
                  if (delay_dec == '0) begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_RELEASE: begin
                  oe_in        = 1'b0;
                  dout_in      = 1'b0;
                  bit_index_in = '0;
                  sub_tick_in  = 2'd0;
                  phase_in     = PH_RECV;
               end
               PH_RECV: begin
                  if (sub_tick_ff == 2'd0) begin
                     clk_in      = 1'b1;
                     tx_shift_in = {tx_shift_ff[BYTE_W-2:0], req_ch.sdi_in};
                     sub_tick_in = 2'd1;
                  end else begin
                     clk_in      = 1'b0;
                     sub_tick_in = 2'd0;
                     if (bit_next >= BITS_LAST) begin
                        bit_index_in = '0;
                        phase_in     = PH_REND;
                     end else begin
                        bit_index_in = bit_next;
                     end
                  end
               end
               PH_REND: begin
                  cs_in       = 1'b1;
                  oe_in       = 1'b1;
                  rx_shift_in = tx_shift_ff;
                  is_read_in  = 1'b0;
                  phase_in    = PH_IDLE;
                  valid_res   = 1'b1;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end else begin
            case (req_ch.command)
               CMD_TICK: begin
               end
               CMD_WRITE_DC0, CMD_WRITE_DC1, CMD_READ: begin
                  // load and run the first send tick at once
                  lead_bit_in  = (req_ch.command == CMD_WRITE_DC1);
                  is_read_in   = (req_ch.command == CMD_READ);
                  tx_shift_in  = req_ch.value;
                  bit_index_in = '0;
                  sub_tick_in  = 2'd1;
                  phase_in     = PH_SEND;
                  cs_in        = 1'b0;
                  clk_in       = 1'b0;
                  dout_in      = (req_ch.command == CMD_WRITE_DC1);
                  oe_in        = 1'b1;
               end
               CMD_WAIT_MS: begin
                  cs_in   = 1'b1;
                  dout_in = 1'b1;
                  clk_in  = 1'b0;
                  // accepting tick counts as the first one
                  if (delay_total <= DELAY_ONE) begin
                     delay_left_in = '0;
                  end else begin
                     delay_left_in = delay_total - DELAY_ONE;
                     phase_in      = PH_DELAY;
                  end
               end
               CMD_POWER: begin
                  power_res = 1'b1;
               end
               default: begin
                  err_res = ERR_UNSUPPORTED;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_index_ff  <= '0;
         sub_tick_ff   <= '0;
         tx_shift_ff   <= '0;
         rx_shift_ff   <= '0;
         lead_bit_ff   <= 1'b0;
         is_read_ff    <= 1'b0;
         delay_left_ff <= '0;
         cs_ff         <= 1'b1;
         clk_ff        <= 1'b0;
         dout_ff       <= 1'b0;
         oe_ff         <= 1'b1;
      end else begin
         phase_ff      <= phase_in;
         bit_index_ff  <= bit_index_in;
         sub_tick_ff   <= sub_tick_in;
         tx_shift_ff   <= tx_shift_in;
         rx_shift_ff   <= rx_shift_in;
         lead_bit_ff   <= lead_bit_in;
         is_read_ff    <= is_read_in;
         delay_left_ff <= delay_left_in;
         cs_ff         <= cs_in;
         clk_ff        <= clk_in;
         dout_ff       <= dout_in;
         oe_ff         <= oe_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   logic      r_cs_ff, r_clk_ff, r_dout_ff, r_oe_ff, r_busy_ff;
   logic      r_power_ff, r_iov_ff, r_rvalid_ff;
   byte_type  r_rdata_ff;
   error_type r_err_ff;
   logic      io_voltage_sel;

   // low I/O voltage only for early panels on early boards
   assign io_voltage_sel = !((panel_id_ff < PANEL_ID_LOW_LIMIT) &&
                             (board_revision_ff <= BOARD_REV_LOW_MAX));

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         r_cs_ff     <= cs_in;
         r_clk_ff    <= clk_in;
         r_dout_ff   <= dout_in;
         r_oe_ff     <= oe_in;
         r_busy_ff   <= (phase_in != PH_IDLE);
         r_power_ff  <= power_res;
         r_iov_ff    <= io_voltage_sel;
         r_rdata_ff  <= rx_shift_in;
         r_rvalid_ff <= valid_res;
         r_err_ff    <= err_res;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.spi_cs          = r_cs_ff;
   assign rsp_ch.spi_clk         = r_clk_ff;
   assign rsp_ch.spi_dout        = r_dout_ff;
   assign rsp_ch.dout_enable     = r_oe_ff;
   assign rsp_ch.busy_res        = r_busy_ff;
   assign rsp_ch.power_request   = r_power_ff;
   assign rsp_ch.io_voltage_high = r_iov_ff;
   assign rsp_ch.read_data       = r_rdata_ff;
   assign rsp_ch.read_valid      = r_rvalid_ff;
   assign rsp_ch.error           = r_err_ff;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the 3-wire panel command engine: tick-by-tick prediction and result checking.
`timescale 1ns / 1ps
module tb
   import tws_pkg::*;
;

   // Delay counter width given to the block; it decides where a delay saturates.
   localparam int DELAY_BITS = 24;
   localparam longint unsigned DELAY_MAX = (64'd1 << DELAY_BITS) - 1;

   // Command codes the package leaves unnamed; the block must reject both.
   localparam command_type CMD_SPARE_6 = 3'd6;
   localparam command_type CMD_SPARE_7 = 3'd7;

   // Register index past the last register; writes to it must be dropped.
   localparam csr_index_type CSR_UNUSED = 2'd3;

   // Level on the shared data line during the ticks of a command.
   localparam int SDI_LOW    = 0;
   localparam int SDI_HIGH   = 1;
   localparam int SDI_RANDOM = 2;

   localparam int SETTLE_CYCLES   = 3;    // settle time for the registered result plus margin
   localparam int PHASE_COMMANDS  = 50;   // each random phase runs at least this many tick transactions
   localparam int RANDOM_PHASES   = 6;
   localparam int BUSY_NOISE_PCT  = 10;   // stray commands thrown at a busy block
   localparam int DELAY_TICK_CAP  = 60;   // keeps random delays short
   localparam int HOLD_AT_RESULT  = 300;  // the receiver's long hold-off starts here
   localparam int HOLD_CYCLES     = 80;
   localparam int WATCHDOG_LIMIT  = 1000;

   // Serial link phases, mirroring the engine's sequencing.
   typedef enum logic [2:0] {
      LINK_IDLE,
      LINK_SEND,
      LINK_SEND_END,
      LINK_DELAY,
      LINK_RELEASE,
      LINK_RECV,
      LINK_RECV_END
   } link_phase_type;

   // One result transaction, the pin levels and status after a tick.
   typedef struct packed {
      logic      spi_cs;
      logic      spi_clk;
      logic      spi_dout;
      logic      dout_enable;
      logic      busy_res;
      logic      power_request;
      logic      io_voltage_high;
      byte_type  read_data;
      logic      read_valid;
      error_type error;
   } panel_result_type;

   // Shadow of the engine: advances one tick per accepted command transaction
   // and keeps the results that the engine owes, oldest first.
   class link_scoreboard;
      logic [TPM_W-1:0] ticks_per_ms;
      byte_type         panel_id;
      byte_type         board_rev;

      link_phase_type   phase;
      logic [3:0]       bit_idx;
      logic [1:0]       sub_tick;
      byte_type         tx_shift;
      byte_type         rx_shift;
      logic             lead_bit;
      logic             is_read;
      longint unsigned  delay_left;
      logic             pin_cs, pin_clk, pin_dout, pin_oe;

      panel_result_type expected_results[$];

      int unsigned commands_in, results_out, failures;
      int unsigned writes_sent, reads_done, delays_run, power_pulses;
      int unsigned busy_rejects, unsupported_rejects;

      function new();
         ticks_per_ms = TICKS_PER_MS_RESET;
         panel_id     = '0;
         board_rev    = '0;
         phase        = LINK_IDLE;
         bit_idx      = '0;
         sub_tick     = '0;
         tx_shift     = '0;
         rx_shift     = '0;
         lead_bit     = 1'b0;
         is_read      = 1'b0;
         delay_left   = 0;
         pin_cs       = 1'b1;
         pin_clk      = 1'b0;
         pin_dout     = 1'b0;
         pin_oe       = 1'b1;
      endfunction

      function void write_register(csr_index_type idx, csr_data_type data);
         case (idx)
            CSR_TICKS_PER_MS:   ticks_per_ms = data[TPM_W-1:0];
            CSR_PANEL_ID:       panel_id     = data[BYTE_W-1:0];
            CSR_BOARD_REVISION: board_rev    = data[BYTE_W-1:0];
            default: ;
         endcase
      endfunction

      function bit busy();
         return phase != LINK_IDLE;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // One tick of a running command; returns 1 when a read completes.
      function bit advance_tick(logic sdi);
         logic b;
         case (phase)
            LINK_SEND: begin
               b = (bit_idx == 0) ? lead_bit : tx_shift[8 - bit_idx];
               if (sub_tick == 0) begin
                  pin_cs   = 1'b0;
                  pin_clk  = 1'b0;
                  pin_dout = b;
                  pin_oe   = 1'b1;
                  sub_tick = 1;
               end else if (sub_tick == 1) begin
                  pin_clk  = 1'b1;
                  sub_tick = 2;
               end else begin
                  pin_clk  = 1'b0;
                  sub_tick = 0;
                  if (bit_idx >= 8) begin
                     bit_idx = 0;
                     phase   = is_read ? LINK_RELEASE : LINK_SEND_END;
                  end else begin
                     bit_idx++;
                  end
               end
            end
            LINK_SEND_END: begin
               pin_cs = 1'b1;
               phase  = LINK_IDLE;
            end
            LINK_DELAY: begin
               if (delay_left > 0) delay_left--;
               if (delay_left == 0) phase = LINK_IDLE;
            end
            LINK_RELEASE: begin
               pin_oe   = 1'b0;
               pin_dout = 1'b0;
               bit_idx  = 0;
               sub_tick = 0;
               phase    = LINK_RECV;
            end
            LINK_RECV: begin
               if (sub_tick == 0) begin
                  pin_clk  = 1'b1;
                  tx_shift = {tx_shift[6:0], sdi};
                  sub_tick = 1;
               end else begin
                  pin_clk  = 1'b0;
                  sub_tick = 0;
                  bit_idx++;
                  if (bit_idx >= 8) begin
                     bit_idx = 0;
                     phase   = LINK_RECV_END;
                  end
               end
            end
            LINK_RECV_END: begin
               pin_cs   = 1'b1;
               pin_oe   = 1'b1;
               rx_shift = tx_shift;
               is_read  = 1'b0;
               phase    = LINK_IDLE;
               return 1'b1;
            end
            default: phase = LINK_IDLE;
         endcase
         return 1'b0;
      endfunction

      function void take_command(command_type cmd, byte_type val, logic sdi);
         panel_result_type r;
         error_type       err;
         logic            power;
         logic            done;
         longint unsigned total;
         err   = ERR_NONE;
         power = 1'b0;
         done  = 1'b0;
         commands_in++;
         if (phase != LINK_IDLE) begin
            if (cmd != CMD_TICK) begin
               err = ERR_BUSY;
               busy_rejects++;
            end
            done = advance_tick(sdi);
         end else begin
            case (cmd)
               CMD_TICK: ;
               CMD_WRITE_DC0, CMD_WRITE_DC1, CMD_READ: begin
                  lead_bit = (cmd == CMD_WRITE_DC1);
                  is_read  = (cmd == CMD_READ);
                  tx_shift = val;
                  bit_idx  = 0;
                  sub_tick = 0;
                  phase    = LINK_SEND;
                  if (cmd != CMD_READ) writes_sent++;
                  done = advance_tick(sdi);
               end
               CMD_WAIT_MS: begin
                  pin_cs   = 1'b1;
                  pin_dout = 1'b1;
                  pin_clk  = 1'b0;
                  total    = val;
                  total    = total * ticks_per_ms;
                  if (total > DELAY_MAX) total = DELAY_MAX;
                  if (total <= 1) begin
                     delay_left = 0;
                  end else begin
                     delay_left = total - 1;
                     phase      = LINK_DELAY;
                  end
                  delays_run++;
               end
               CMD_POWER: begin
                  power = 1'b1;
                  power_pulses++;
               end
               default: begin
                  err = ERR_UNSUPPORTED;
                  unsupported_rejects++;
               end
            endcase
         end
         if (done) reads_done++;
         r.spi_cs          = pin_cs;
         r.spi_clk         = pin_clk;
         r.spi_dout        = pin_dout;
         r.dout_enable     = pin_oe;
         r.busy_res        = (phase != LINK_IDLE);
         r.power_request   = power;
         r.io_voltage_high = !(panel_id < PANEL_ID_LOW_LIMIT && board_rev <= BOARD_REV_LOW_MAX);
         r.read_data       = rx_shift;
         r.read_valid      = done;
         r.error           = err;
         expected_results.push_back(r);
      endfunction

      function void check_result(panel_result_type got);
         panel_result_type want;
         results_out++;
         if (expected_results.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("result %0d arrived with nothing expected: %p", results_out, got);
            return;
         end
         want = expected_results.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= 10)
               $display("result %0d mismatch\n  expected %p\n  actual   %p",
                        results_out, want, got);
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          csr_write_enable;
   csr_index_type csr_index;
   csr_data_type  csr_write_data;
   bit            sender_burst;
   int unsigned   quiet_cycles = 0;

   link_scoreboard prediction = new();

   tws_req_if req_bus ();
   tws_rsp_if rsp_bus ();

   three_wire_spi_panel_command_engine #(
      .DELAY_COUNT_BITS(DELAY_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Watchdog: the run is dead if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   function automatic logic pick_sdi(int mode);
      if (mode == SDI_LOW) return 1'b0;
      if (mode == SDI_HIGH) return 1'b1;
      return logic'($urandom_range(0, 1));
   endfunction

   // Offer one tick transaction after a random gap; the shadow advances at the
   // edge where it is taken, so the next decision sees the engine's new phase.
   task automatic send_item(input command_type cmd, input byte_type val, input logic sdi);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= cmd;
      req_bus.value   <= val;
      req_bus.sdi_in  <= sdi;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      prediction.take_command(cmd, val, sdi);
   endtask

   // Issue a command, then keep ticking until the engine is idle again.
   // Some of the ticks carry stray commands, which a busy engine must reject.
   task automatic run_command(input command_type cmd, input byte_type val,
                              input int sdi_mode, input int noise_pct);
      command_type filler;
      send_item(cmd, val, pick_sdi(sdi_mode));
      while (prediction.busy()) begin
         if ($urandom_range(0, 99) < noise_pct)
            filler = command_type'($urandom_range(1, 7));
         else
            filler = CMD_TICK;
         send_item(filler, byte_type'($urandom), pick_sdi(sdi_mode));
      end
   endtask

   task automatic put_register(input csr_index_type idx, input csr_data_type data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      prediction.write_register(idx, data);
   endtask

   // Registers change only with the engine idle and every result delivered.
   // The byte-wide registers get junk in their upper bits, which must be dropped,
   // and the spare index gets a write that must have no effect.
   task automatic write_settings(input logic [TPM_W-1:0] tpm, input byte_type pid,
                                 input byte_type rev);
      req_bus.valid <= 1'b0;
      while (prediction.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      put_register(CSR_TICKS_PER_MS, tpm);
      put_register(CSR_PANEL_ID, {byte_type'($urandom), pid});
      put_register(CSR_BOARD_REVISION, {byte_type'($urandom), rev});
      put_register(CSR_UNUSED, csr_data_type'($urandom));
      csr_write_enable <= 1'b0;
   endtask

   // Result side: random stalls, stretches without stalls, and one long
   // hold-off so the engine's output register fills and it stops taking ticks.
   initial begin : result_sink
      int stall;
      int taken;
      bit fast;
      panel_result_type seen;
      taken = 0;
      fast  = 1'b0;
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         stall = fast ? 0 : $urandom_range(0, 6);
         if (taken == HOLD_AT_RESULT) stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         seen.spi_cs          = rsp_bus.spi_cs;
         seen.spi_clk         = rsp_bus.spi_clk;
         seen.spi_dout        = rsp_bus.spi_dout;
         seen.dout_enable     = rsp_bus.dout_enable;
         seen.busy_res        = rsp_bus.busy_res;
         seen.power_request   = rsp_bus.power_request;
         seen.io_voltage_high = rsp_bus.io_voltage_high;
         seen.read_data       = rsp_bus.read_data;
         seen.read_valid      = rsp_bus.read_valid;
         seen.error           = rsp_bus.error;
         prediction.check_result(seen);
         taken++;
         if (taken % 40 == 0) fast = ($urandom_range(0, 2) == 0);
      end
   end

   // Main sequence: reset, directed commands, then random phases that each
   // start from a new register setting.
   initial begin : command_source
      logic [TPM_W-1:0] tpm_set[RANDOM_PHASES];
      byte_type         pid_set[RANDOM_PHASES];
      byte_type         rev_set[RANDOM_PHASES];
      int unsigned      phase_start;
      int               pick;
      int               max_val;
      command_type      cmd;
      byte_type         val;

      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_TICKS_PER_MS;
      csr_write_data   <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.command  <= CMD_TICK;
      req_bus.value    <= '0;
      req_bus.sdi_in   <= 1'b0;
      sender_burst      = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle tick, both unsupported codes, power pulse, then
      // writes with all-zero, all-one and mixed bytes (with stray commands
      // while busy), reads sampling a constant low, constant high and random
      // line, and a zero-length delay at the reset rate.
      run_command(CMD_TICK, 8'h00, SDI_RANDOM, 0);
      run_command(CMD_SPARE_6, 8'h00, SDI_RANDOM, 0);
      run_command(CMD_SPARE_7, 8'hFF, SDI_RANDOM, 0);
      run_command(CMD_POWER, 8'h5A, SDI_RANDOM, 0);
      run_command(CMD_WRITE_DC0, 8'h00, SDI_RANDOM, 0);
      run_command(CMD_WRITE_DC1, 8'hFF, SDI_RANDOM, 30);
      run_command(CMD_WRITE_DC0, 8'hA5, SDI_RANDOM, 0);
      run_command(CMD_READ, 8'h0A, SDI_HIGH, 0);
      run_command(CMD_READ, 8'hDA, SDI_LOW, 0);
      run_command(CMD_READ, 8'h04, SDI_RANDOM, 20);
      run_command(CMD_WAIT_MS, 8'h00, SDI_RANDOM, 0);

      // One tick per millisecond: a one-millisecond delay ends at once, a
      // longer delay runs out its full count. Panel 1 on revision 2 is the
      // last combination that still selects the low I/O voltage.
      write_settings(16'd1, 8'd1, 8'd2);
      run_command(CMD_WAIT_MS, 8'h01, SDI_RANDOM, 0);
      run_command(CMD_WAIT_MS, 8'h40, SDI_RANDOM, 5);
      run_command(CMD_POWER, 8'h00, SDI_RANDOM, 0);

      // Zero ticks per millisecond: any delay completes in its own tick.
      // Panel 2 is the first that selects the high I/O voltage.
      write_settings(16'd0, 8'd2, 8'd0);
      run_command(CMD_WAIT_MS, 8'hC8, SDI_RANDOM, 0);
      run_command(CMD_POWER, 8'h00, SDI_RANDOM, 0);
      run_command(CMD_WRITE_DC1, 8'h3C, SDI_RANDOM, 0);

      // Register settings for the random phases, extremes first.
      tpm_set[0] = 16'd1;     pid_set[0] = 8'd0;   rev_set[0] = 8'd0;
      tpm_set[1] = 16'hFFFF;  pid_set[1] = 8'hFF;  rev_set[1] = 8'hFF;
      tpm_set[2] = 16'd0;     pid_set[2] = 8'd1;   rev_set[2] = 8'd2;
      tpm_set[3] = 16'd2;     pid_set[3] = 8'd0;   rev_set[3] = 8'd3;
      tpm_set[4] = 16'd3;     pid_set[4] = 8'd2;   rev_set[4] = 8'd1;
      tpm_set[5] = 16'($urandom_range(1, 8));
      pid_set[5] = byte_type'($urandom_range(0, 3));
      rev_set[5] = byte_type'($urandom_range(0, 4));

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         sender_burst = (p % 2 == 1);
         write_settings(tpm_set[p], pid_set[p], rev_set[p]);
         phase_start = prediction.commands_in;
         while (prediction.commands_in - phase_start < PHASE_COMMANDS) begin
            pick = $urandom_range(0, 99);
            val  = byte_type'($urandom);
            if (pick < 18)      cmd = CMD_WRITE_DC0;
            else if (pick < 36) cmd = CMD_WRITE_DC1;
            else if (pick < 56) cmd = CMD_READ;
            else if (pick < 68) cmd = CMD_WAIT_MS;
            else if (pick < 76) cmd = CMD_POWER;
            else if (pick < 86) cmd = CMD_TICK;
            else if (pick < 93) cmd = CMD_SPARE_6;
            else                cmd = CMD_SPARE_7;
            // keep delays to a few dozen ticks at whatever rate is set
            if (cmd == CMD_WAIT_MS && tpm_set[p] != 0) begin
               max_val = DELAY_TICK_CAP / tpm_set[p];
               if (max_val > 255) max_val = 255;
               val = byte_type'($urandom_range(0, max_val));
            end
            run_command(cmd, val, SDI_RANDOM, BUSY_NOISE_PCT);
         end
      end

      req_bus.valid <= 1'b0;
      while (prediction.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES + 1) @(posedge clock);
      if (prediction.pending() != 0) prediction.failures += prediction.pending();

      $display("ran %0d tick transactions: %0d writes, %0d reads, %0d delays, %0d power pulses",
               prediction.commands_in, prediction.writes_sent, prediction.reads_done,
               prediction.delays_run, prediction.power_pulses);
      $display("rejected %0d commands while busy and %0d unsupported; %0d results, %0d mismatches",
               prediction.busy_rejects, prediction.unsupported_rejects,
               prediction.results_out, prediction.failures);
      if (prediction.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
